### hdl/pfnfa_pkg.sv
// Shared types and constants for the postfix regex to NFA builder.
package pfnfa_pkg;

    // Width of state numbers as reported on the result channel
    localparam int STATE_OUT_W = 8;
    // Most results one token can cause: the edges of an alternate or star plus the final report
    localparam int MAX_RESULTS = 5;
    localparam int RES_IDX_W   = 3;

    // Token kinds
    typedef enum logic [2:0] {
        ACT_LITERAL   = 3'd0,
        ACT_CONCAT    = 3'd1,
        ACT_ALTERNATE = 3'd2,
        ACT_STAR      = 3'd3,
        ACT_PLUS      = 3'd4,
        ACT_OPTIONAL  = 3'd5
    } action_e;

    // Result kinds
    localparam logic [1:0] KIND_EDGE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_UNDER  = 2'd1;
    localparam logic [1:0] ERR_OVER   = 2'd2;
    localparam logic [1:0] ERR_STATES = 2'd3;

    // Fragment stack operations, top of stack in cell 0
    typedef enum logic [1:0] {
        STK_HOLD    = 2'd0,
        STK_PUSH    = 2'd1,   // every cell takes the one above, cell 0 the new entry
        STK_POP     = 2'd2,   // every cell takes the one below, cell 0 the new entry
        STK_REPLACE = 2'd3    // only cell 0 takes the new entry
    } stk_op_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] symbol;
        logic       final_token;
    } tok_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] from_state;
        logic [7:0] to_state;
        logic       slot;
        logic       is_epsilon;
        logic [7:0] label;
        logic [1:0] error_code;
        logic       last_of_run;
    } res_t;

    // Edge write result
    function automatic res_t mk_edge(logic [7:0] from_s, logic [7:0] to_s, logic slot,
                                     logic eps, logic [7:0] label);
        res_t r;
        r.kind        = KIND_EDGE;
        r.from_state  = from_s;
        r.to_state    = to_s;
        r.slot        = slot;
        r.is_epsilon  = eps;
        r.label       = label;
        r.error_code  = ERR_NONE;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Error report result
    function automatic res_t mk_error(logic [1:0] code);
        res_t r;
        r             = '0;
        r.kind        = KIND_ERROR;
        r.error_code  = code;
        return r;
    endfunction

    // Finished expression result
    function automatic res_t mk_done(logic [7:0] start_s, logic [7:0] end_s);
        res_t r;
        r            = '0;
        r.kind       = KIND_DONE;
        r.from_state = start_s;
        r.to_state   = end_s;
        return r;
    endfunction

endpackage

### hdl/pfnfa_cell.sv
// One entry of the fragment stack, shifting with its neighbors.
module pfnfa_cell #(
    parameter int W = 16
) (
    input  logic                 clk,
    input  pfnfa_pkg::stk_op_t   op,
    input  logic [W-1:0]         above,
    input  logic [W-1:0]         below,
    output logic [W-1:0]         q
);
    import pfnfa_pkg::*;

    logic [W-1:0] val_reg;

    // Take the neighbor's entry on a shift, hold otherwise
    always_ff @(posedge clk)
    begin
        case (op)
            STK_PUSH: val_reg <= above;
            STK_POP:  val_reg <= below;
            default:  val_reg <= val_reg;
        endcase
    end

    assign q = val_reg;

endmodule

### hdl/postfix_regex_to_nfa_builder_top.sv
// Top level of the postfix regex to NFA builder: stack of cells and result sequencer.
//
//   channel  | handshake            | payload            | role
//   ---------+----------------------+--------------------+----------------------------
//   token    | tok_valid, tok_stall | tok_data (tok_t)   | postfix tokens in
//   result   | res_valid, res_stall | res_data (res_t)   | edge writes, done, errors out
//
// A token is decoded in the cycle it is taken; its results leave one per cycle
// while the result channel does not stall. A literal or concat gives one result,
// plus and optional three, alternate and star four, an error one, and a final
// token one more. The next token is taken in the cycle its predecessor's last
// result moves to the output register. Reset clears the stack count and the
// state counter; stack cells are not cleared.
module postfix_regex_to_nfa_builder_top #(
    parameter int MAX_STATES  = 256,
    parameter int STACK_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    output logic              tok_stall,
    input  pfnfa_pkg::tok_t   tok_data,
    output logic              res_valid,
    input  logic              res_stall,
    output pfnfa_pkg::res_t   res_data
);
    import pfnfa_pkg::*;

    localparam int SW = $clog2(MAX_STATES);
    localparam int NW = $clog2(MAX_STATES + 1);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int FW = 2 * SW;

    // Counters
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] nsn_reg, nsn_next;

    // Result buffer
    res_t                 pend_reg [MAX_RESULTS];
    logic [RES_IDX_W-1:0] pend_cnt_reg;
    logic [RES_IDX_W-1:0] pend_idx_reg;
    logic                 res_valid_reg;
    res_t                 res_reg;

    // Decode outputs
    res_t                 list [MAX_RESULTS];
    logic [RES_IDX_W-1:0] n_res;
    stk_op_t              op;
    stk_op_t              cell_op;
    logic [FW-1:0]        new_frag;

    logic [FW-1:0] cell_q [STACK_DEPTH];

    logic has_pend, out_free, move, last_move, acc;

    // Stack as a row of cells, top in cell 0
    generate
        for (genvar i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            stk_op_t       op_i;
            logic [FW-1:0] above_i;
            logic [FW-1:0] below_i;

            if (i == 0)
            begin : g_first
                assign op_i    = (cell_op == STK_HOLD) ? STK_HOLD : STK_PUSH;
                assign above_i = new_frag;
            end
            else
            begin : g_rest
                assign op_i    = (cell_op == STK_REPLACE) ? STK_HOLD : cell_op;
                assign above_i = cell_q[i-1];
            end

            if (i == STACK_DEPTH - 1)
            begin : g_last
                assign below_i = '0;
            end
            else
            begin : g_mid
                assign below_i = cell_q[i+1];
            end

            pfnfa_cell #(.W(FW)) u_cell (
                .clk   (clk),
                .op    (op_i),
                .above (above_i),
                .below (below_i),
                .q     (cell_q[i])
            );
        end
    endgenerate

    // Token decode: edges, stack operation and counter updates
    always_comb
    begin
        logic [SW-1:0]          a, b;
        logic [SW-1:0]          ts, te, ls, le;
        logic [STATE_OUT_W-1:0] a8, b8, ts8, te8, ls8, le8;
        logic                   short_states, full;
        logic [FW-1:0]          post_top;

        a  = nsn_reg[SW-1:0];
        b  = a + SW'(1);
        ts = cell_q[0][FW-1:SW];
        te = cell_q[0][SW-1:0];
        ls = cell_q[1][FW-1:SW];
        le = cell_q[1][SW-1:0];
        a8  = STATE_OUT_W'(a);
        b8  = STATE_OUT_W'(b);
        ts8 = STATE_OUT_W'(ts);
        te8 = STATE_OUT_W'(te);
        ls8 = STATE_OUT_W'(ls);
        le8 = STATE_OUT_W'(le);
        short_states = (nsn_reg > NW'(MAX_STATES - 2));
        full         = (cnt_reg == CW'(STACK_DEPTH));

        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            list[k] = '0;
        end
        n_res    = '0;
        op       = STK_HOLD;
        new_frag = '0;
        cnt_next = cnt_reg;
        nsn_next = nsn_reg;

        case (tok_data.action)
            ACT_LITERAL:
            begin
                if (full)
                begin
                    list[0] = mk_error(ERR_OVER);
                    n_res   = RES_IDX_W'(1);
                end
                else if (short_states)
                begin
                    list[0] = mk_error(ERR_STATES);
                    n_res   = RES_IDX_W'(1);
                end
                else
                begin
                    list[0]  = mk_edge(a8, b8, 1'b0, 1'b0, tok_data.symbol);
                    n_res    = RES_IDX_W'(1);
                    op       = STK_PUSH;
                    new_frag = {a, b};
                    cnt_next = cnt_reg + CW'(1);
                    nsn_next = nsn_reg + NW'(2);
                end
            end
            ACT_CONCAT:
            begin
                if (cnt_reg < CW'(2))
                begin
                    list[0] = mk_error(ERR_UNDER);
                    n_res   = RES_IDX_W'(1);
                end
                else
                begin
                    list[0]  = mk_edge(le8, ts8, 1'b0, 1'b1, '0);
                    n_res    = RES_IDX_W'(1);
                    op       = STK_POP;
                    new_frag = {ls, te};
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ACT_ALTERNATE:
            begin
                if (cnt_reg < CW'(2))
                begin
                    list[0] = mk_error(ERR_UNDER);
                    n_res   = RES_IDX_W'(1);
                end
                else if (short_states)
                begin
                    list[0] = mk_error(ERR_STATES);
                    n_res   = RES_IDX_W'(1);
                end
                else
                begin
                    list[0]  = mk_edge(a8, ls8, 1'b0, 1'b1, '0);
                    list[1]  = mk_edge(a8, ts8, 1'b1, 1'b1, '0);
                    list[2]  = mk_edge(le8, b8, 1'b0, 1'b1, '0);
                    list[3]  = mk_edge(te8, b8, 1'b0, 1'b1, '0);
                    n_res    = RES_IDX_W'(4);
                    op       = STK_POP;
                    new_frag = {a, b};
                    cnt_next = cnt_reg - CW'(1);
                    nsn_next = nsn_reg + NW'(2);
                end
            end
            ACT_STAR, ACT_PLUS, ACT_OPTIONAL:
            begin
                if (cnt_reg == '0)
                begin
                    list[0] = mk_error(ERR_UNDER);
                    n_res   = RES_IDX_W'(1);
                end
                else if (short_states)
                begin
                    list[0] = mk_error(ERR_STATES);
                    n_res   = RES_IDX_W'(1);
                end
                else
                begin
                    list[0] = mk_edge(a8, ts8, 1'b0, 1'b1, '0);
                    if (tok_data.action == ACT_OPTIONAL)
                    begin
                        list[1] = mk_edge(te8, b8, 1'b0, 1'b1, '0);
                        list[2] = mk_edge(a8, b8, 1'b1, 1'b1, '0);
                        n_res   = RES_IDX_W'(3);
                    end
                    else
                    begin
                        list[1] = mk_edge(te8, ts8, 1'b1, 1'b1, '0);
                        list[2] = mk_edge(te8, b8, 1'b0, 1'b1, '0);
                        list[3] = mk_edge(a8, b8, 1'b1, 1'b1, '0);
                        n_res   = (tok_data.action == ACT_STAR) ? RES_IDX_W'(4)
                                                                : RES_IDX_W'(3);
                    end
                    op       = STK_REPLACE;
                    new_frag = {a, b};
                    nsn_next = nsn_reg + NW'(2);
                end
            end
            default:
            begin
                n_res = '0;
            end
        endcase

        // Final token reports the top fragment left after this token
        post_top = (op == STK_HOLD) ? cell_q[0] : new_frag;
        if (tok_data.final_token)
        begin
            if (cnt_next == '0)
            begin
                list[n_res] = mk_error(ERR_UNDER);
            end
            else
            begin
                list[n_res] = mk_done(STATE_OUT_W'(post_top[FW-1:SW]),
                                      STATE_OUT_W'(post_top[SW-1:0]));
            end
            n_res    = n_res + RES_IDX_W'(1);
            cnt_next = '0;
            nsn_next = '0;
        end

        if (n_res != '0)
        begin
            list[n_res - RES_IDX_W'(1)].last_of_run = 1'b1;
        end
    end

    // Handshake: take a token once the buffer is drained or drains now
    assign has_pend  = (pend_idx_reg != pend_cnt_reg);
    assign out_free  = !res_valid_reg || !res_stall;
    assign move      = has_pend && out_free;
    assign last_move = move && ((pend_idx_reg + RES_IDX_W'(1)) == pend_cnt_reg);
    assign tok_stall = has_pend && !last_move;
    assign acc       = tok_valid && !tok_stall;
    assign cell_op   = acc ? op : STK_HOLD;

    // Counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            nsn_reg <= '0;
        end
        else if (acc)
        begin
            cnt_reg <= cnt_next;
            nsn_reg <= nsn_next;
        end
    end

    // Result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg  <= '0;
            pend_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                pend_cnt_reg <= n_res;
                pend_idx_reg <= '0;
            end
            else if (move)
            begin
                pend_idx_reg <= pend_idx_reg + RES_IDX_W'(1);
            end
            if (out_free)
            begin
                res_valid_reg <= move;
            end
        end
    end

    // Result buffer and output payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                pend_reg[k] <= list[k];
            end
        end
        if (move)
        begin
            res_reg <= pend_reg[pend_idx_reg];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTH
    // Read pointer never passes the fill count
    a_idx_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pend_idx_reg <= pend_cnt_reg)
        else $error("result read pointer beyond fill count");

    // Stack count never exceeds the depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("fragment stack count beyond depth");

    // A final token leaves an empty stack and a fresh state counter
    a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && tok_data.final_token) |=> (cnt_reg == '0 && nsn_reg == '0))
        else $error("final token did not clear the builder");
`endif

endmodule
